>>> hw/rtl/cpb_pkg.sv
// Shared types and constants for the column predicate bitmap block.
`timescale 1ns / 1ps
package cpb_pkg;
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	localparam logic [2:0] OP_EQ = 3'd0;
	localparam logic [2:0] OP_NE = 3'd1;
	localparam logic [2:0] OP_LT = 3'd2;
	localparam logic [2:0] OP_LE = 3'd3;
	localparam logic [2:0] OP_GT = 3'd4;
	localparam logic [2:0] OP_GE = 3'd5;

	localparam logic [3:0] TYPE_F32 = 4'd8;
	localparam logic [3:0] TYPE_F64 = 4'd9;

	localparam logic [1:0] MODE_SCALAR = 2'd0;
	localparam logic [1:0] MODE_COLUMN = 2'd1;
	localparam logic [1:0] MODE_RANGE  = 2'd2;

	localparam logic [2:0] REG_OP    = 3'd0;
	localparam logic [2:0] REG_TYPE  = 3'd1;
	localparam logic [2:0] REG_MODE  = 3'd2;
	localparam logic [2:0] REG_CMP   = 3'd3;
	localparam logic [2:0] REG_LOW   = 3'd4;
	localparam logic [2:0] REG_HIGH  = 3'd5;

	// Compare outcome of one operand pair, taken by the back end.
	typedef struct packed {
		logic lt;
		logic eq;
		logic unord;
	} rel_t;

	// One classified element in the queue.
	typedef struct packed {
		rel_t r0;
		rel_t r1;
		logic live;
		logic last;
	} item_t;

	// Order key: integer keys with sign flip for signed types; floats are compared separately in rel_calc.
	function automatic logic [63:0] order_key(input logic [3:0] t, input logic [63:0] raw);
		logic [63:0] v;
		v = 64'd0;
		case (t[1:0])
			2'd0: v = {56'd0, raw[7:0] ^ {t[2] ? 1'b0 : 1'b1, 7'd0}};
			2'd1: v = {48'd0, raw[15:0] ^ {t[2] ? 1'b0 : 1'b1, 15'd0}};
			2'd2: v = {32'd0, raw[31:0] ^ {t[2] ? 1'b0 : 1'b1, 31'd0}};
			default: v = raw ^ {~t[2], 63'd0};
		endcase
		return v;
	endfunction

	function automatic rel_t rel_calc(input logic [3:0] t, input logic [63:0] a,
		input logic [63:0] b);
		rel_t r;
		logic [63:0] ka, kb;
		logic na, nb, za, zb, sa, sb;
		r = '0;
		ka = order_key(t, a);
		kb = order_key(t, b);
		if (t == TYPE_F32) begin
			na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
			nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
			za = a[30:0] == 31'd0;
			zb = b[30:0] == 31'd0;
			sa = a[31];
			sb = b[31];
			r.unord = na | nb;
			r.eq = (a[31:0] == b[31:0]) | (za & zb);
			if (za & zb) r.lt = 1'b0;
			else if (sa != sb) r.lt = sa;
			else r.lt = sa ? (a[30:0] > b[30:0]) : (a[30:0] < b[30:0]);
		end else if (t == TYPE_F64) begin
			na = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
			nb = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
			za = a[62:0] == 63'd0;
			zb = b[62:0] == 63'd0;
			sa = a[63];
			sb = b[63];
			r.unord = na | nb;
			r.eq = (a == b) | (za & zb);
			if (za & zb) r.lt = 1'b0;
			else if (sa != sb) r.lt = sa;
			else r.lt = sa ? (a[62:0] > b[62:0]) : (a[62:0] < b[62:0]);
		end else begin
			r.unord = t > TYPE_F64;
			r.eq = ka == kb;
			r.lt = ka < kb;
		end
		return r;
	endfunction
endpackage

>>> hw/rtl/cpb_front.sv
// Front end: takes elements, runs the typed compares and registers the outcome.
`timescale 1ns / 1ps
module cpb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [63:0]         value_a,
	input  logic [63:0]         value_b,
	input  logic                valid_a,
	input  logic                valid_b,
	input  logic                is_last,
	input  logic [3:0]          element_type,
	input  logic [1:0]          compare_mode,
	input  logic [63:0]         comparand,
	input  logic [63:0]         range_low,
	input  logic [63:0]         range_high,
	output logic                item_valid,
	input  logic                item_ready,
	output cpb_pkg::item_t      item
);
	logic [63:0] opnd0, opnd1;
	cpb_pkg::item_t item_s1;
	logic valid_s1;

	always_comb begin
		opnd0 = comparand;
		opnd1 = range_high;
		unique case (compare_mode)
			cpb_pkg::MODE_COLUMN: opnd0 = value_b;
			cpb_pkg::MODE_RANGE:  opnd0 = range_low;
			default:              opnd0 = comparand;
		endcase
	end

	assign in_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Undefined element types and the undefined mode never match, whatever the operation.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.r0 <= cpb_pkg::rel_calc(element_type, value_a, opnd0);
			item_s1.r1 <= cpb_pkg::rel_calc(element_type, value_a, opnd1);
			item_s1.live <= valid_a && (compare_mode != cpb_pkg::MODE_COLUMN || valid_b)
				&& compare_mode != 2'd3 && element_type <= cpb_pkg::TYPE_F64;
			item_s1.last <= is_last;
		end
	end

	assign item_valid = valid_s1;
	assign item = item_s1;
endmodule

>>> hw/rtl/cpb_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module cpb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  cpb_pkg::item_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output cpb_pkg::item_t rd_data
);
	cpb_pkg::item_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           wr_en, rd_en;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !rd_en) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wp_q == rp_q))
		else $error("empty queue pointers disagree");
endmodule

>>> hw/rtl/cpb_back.sv
// Back end: resolves the predicate, packs bits and keeps the running count.
`timescale 1ns / 1ps
module cpb_back #(
	parameter int unsigned COUNT_WIDTH = cpb_pkg::COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     compare_op,
	input  logic [1:0]     compare_mode,
	input  logic           item_valid,
	output logic           item_ready,
	input  cpb_pkg::item_t item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic [31:0]    match_count,
	output logic           final_byte
);
	logic [7:0] acc_q;
	logic [2:0] pos_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic pred, rel0, emit, take;
	logic [7:0] acc_nx;
	logic [COUNT_WIDTH-1:0] cnt_nx;
	logic ov_q;
	logic [7:0] ob_q;
	logic [31:0] oc_q;
	logic of_q;

	function automatic logic rel_op(input logic [2:0] op, input cpb_pkg::rel_t r);
		logic p;
		p = 1'b0;
		unique case (op)
			cpb_pkg::OP_EQ: p = !r.unord && r.eq;
			cpb_pkg::OP_NE: p = r.unord || !r.eq;
			cpb_pkg::OP_LT: p = !r.unord && r.lt;
			cpb_pkg::OP_LE: p = !r.unord && (r.lt || r.eq);
			cpb_pkg::OP_GT: p = !r.unord && !r.lt && !r.eq;
			cpb_pkg::OP_GE: p = !r.unord && !r.lt;
			default:        p = 1'b0;
		endcase
		return p;
	endfunction

	always_comb begin
		if (compare_mode == cpb_pkg::MODE_RANGE)
			rel0 = rel_op(cpb_pkg::OP_GE, item.r0) && rel_op(cpb_pkg::OP_LE, item.r1);
		else
			rel0 = rel_op(compare_op, item.r0);
		pred = item.live && rel0;
		acc_nx = acc_q | (pred ? (8'd1 << pos_q) : 8'd0);
		cnt_nx = cnt_q + COUNT_WIDTH'(pred);
		emit = (pos_q == 3'd7) || item.last;
	end

	assign item_ready = !ov_q || out_ready;
	assign take = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'd0;
			pos_q <= 3'd0;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (take && emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (take) begin
				pos_q <= emit ? 3'd0 : pos_q + 3'd1;
				acc_q <= emit ? 8'd0 : acc_nx;
				cnt_q <= item.last ? '0 : cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			ob_q <= acc_nx;
			oc_q <= 32'(cnt_nx);
			of_q <= item.last;
		end
	end

	assign out_valid = ov_q;
	assign out_byte = ob_q;
	assign match_count = oc_q;
	assign final_byte = of_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.last) |=> (pos_q == 3'd0 && cnt_q == '0))
		else $error("column end did not clear state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && !emit) |=> (pos_q == $past(pos_q) + 3'd1))
		else $error("bit position skipped");
endmodule

>>> hw/rtl/column_predicate_bitmap.sv
`timescale 1ns / 1ps
// Top level of the column predicate scan with packed validity bitmap output.
//
//  Channel | Handshake              | Payload
//  s_axis  | s_axis_tvalid/tready   | tdata{value_b,value_a}, tuser{valid_b,valid_a}, tlast=is_last
//  m_axis  | m_axis_tvalid/tready   | tdata{match_count,out_byte}, tlast=final_byte
//  cfg     | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One element per cycle is sustained while the result side does not stall; an element
// passes from the compare stage through the queue and the pack stage to the result register.
// Reset clears the packing state, running count, queue, valid flags and configuration registers.
// A stall on the result side fills the two-entry queue and the compare stage before
// input is held.
module column_predicate_bitmap #(
	parameter int unsigned COUNT_WIDTH = cpb_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,  // value_a [63:0], value_b [127:64]
	input  logic [1:0]    s_axis_tuser,  // valid_a [0], valid_b [1]
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [39:0]   m_axis_tdata,  // out_byte [7:0], match_count [39:8]
	output logic          m_axis_tlast,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	logic [2:0]  op_q;
	logic [3:0]  type_q;
	logic [1:0]  mode_q;
	logic [63:0] cmp_q, low_q, high_q;
	logic        fv, fr, bv, br;
	cpb_pkg::item_t fi, bi;

	// Configuration is always accepted; writes must land only while the block is idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
			type_q <= '0;
			mode_q <= '0;
			cmp_q <= '0;
			low_q <= '0;
			high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cpb_pkg::REG_OP:   op_q <= cfg_data[2:0];
				cpb_pkg::REG_TYPE: type_q <= cfg_data[3:0];
				cpb_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				cpb_pkg::REG_CMP:  cmp_q <= cfg_data;
				cpb_pkg::REG_LOW:  low_q <= cfg_data;
				cpb_pkg::REG_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cpb_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.value_a(s_axis_tdata[63:0]), .value_b(s_axis_tdata[127:64]),
		.valid_a(s_axis_tuser[0]), .valid_b(s_axis_tuser[1]), .is_last(s_axis_tlast),
		.element_type(type_q), .compare_mode(mode_q), .comparand(cmp_q),
		.range_low(low_q), .range_high(high_q),
		.item_valid(fv), .item_ready(fr), .item(fi)
	);

	cpb_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fv), .wr_ready(fr), .wr_data(fi),
		.rd_valid(bv), .rd_ready(br), .rd_data(bi)
	);

	cpb_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.compare_op(op_q), .compare_mode(mode_q),
		.item_valid(bv), .item_ready(br), .item(bi),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_byte(m_axis_tdata[7:0]), .match_count(m_axis_tdata[39:8]),
		.final_byte(m_axis_tlast)
	);
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the column predicate bitmap block.

// One packed result byte as the block should report it.
typedef struct packed {
	logic [7:0]  bits;
	logic [31:0] count;
	logic        last;
} bitmap_byte_t;

// Tracks the block's packing state and configuration, and checks each result byte.
class bitmap_scoreboard;
	logic [2:0]   op;
	logic [3:0]   etype;
	logic [1:0]   mode;
	logic [63:0]  cmp_val;
	logic [63:0]  lo_val;
	logic [63:0]  hi_val;
	logic [7:0]   acc;
	logic [2:0]   pos;
	logic [31:0]  count;
	bitmap_byte_t pending[$];
	int           errors;
	int           bytes_seen;
	int           columns_seen;

	function new();
		op = cpb_pkg::OP_EQ;
		etype = 4'd0;
		mode = cpb_pkg::MODE_SCALAR;
		cmp_val = '0;
		lo_val = '0;
		hi_val = '0;
		acc = '0;
		pos = '0;
		count = '0;
		errors = 0;
		bytes_seen = 0;
		columns_seen = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] data);
		case (idx)
			cpb_pkg::REG_OP: op = data[2:0];
			cpb_pkg::REG_TYPE: etype = data[3:0];
			cpb_pkg::REG_MODE: mode = data[1:0];
			cpb_pkg::REG_CMP: cmp_val = data;
			cpb_pkg::REG_LOW: lo_val = data;
			cpb_pkg::REG_HIGH: hi_val = data;
			default: ;
		endcase
	endfunction

	// Turns less-than and equal flags into the outcome of one compare operation.
	function bit apply_op(logic [2:0] o, bit lt, bit eq);
		case (o)
			cpb_pkg::OP_EQ: return eq;
			cpb_pkg::OP_NE: return !eq;
			cpb_pkg::OP_LT: return lt;
			cpb_pkg::OP_LE: return lt | eq;
			cpb_pkg::OP_GT: return !lt && !eq;
			cpb_pkg::OP_GE: return !lt;
			default: return 1'b0;
		endcase
	endfunction

	// Integers are compared as unsigned keys; signed types get the sign bit flipped.
	function logic [63:0] int_key(logic [3:0] t, logic [63:0] raw);
		int w;
		logic [63:0] v;
		w = 8 << t[1:0];
		v = (w == 64) ? raw : (raw & ((64'd1 << w) - 64'd1));
		if (t < 4)
			v[w-1] = ~v[w-1];
		return v;
	endfunction

	// Ordered float compare on sign-magnitude bits; a NaN fails all but not-equal.
	function bit float_holds(logic [2:0] o, bit dbl, logic [63:0] a, logic [63:0] b);
		bit sa, sb, na, nb, lt, eq;
		logic [62:0] ma, mb;
		if (dbl) begin
			sa = a[63];
			sb = b[63];
			ma = a[62:0];
			mb = b[62:0];
			na = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
			nb = (b[62:52] == 11'h7FF) && (b[51:0] != 0);
		end else begin
			sa = a[31];
			sb = b[31];
			ma = {32'd0, a[30:0]};
			mb = {32'd0, b[30:0]};
			na = (a[30:23] == 8'hFF) && (a[22:0] != 0);
			nb = (b[30:23] == 8'hFF) && (b[22:0] != 0);
		end
		if (na || nb)
			return o == cpb_pkg::OP_NE;
		eq = (ma == 0 && mb == 0) || (sa == sb && ma == mb);
		if (eq)
			lt = 1'b0;
		else if (sa != sb)
			lt = sa;
		else
			lt = sa ? (ma > mb) : (ma < mb);
		return apply_op(o, lt, eq);
	endfunction

	function bit holds(logic [2:0] o, logic [63:0] a, logic [63:0] b);
		logic [63:0] ka, kb;
		if (etype < 8) begin
			ka = int_key(etype, a);
			kb = int_key(etype, b);
			return apply_op(o, ka < kb, ka == kb);
		end
		if (etype == cpb_pkg::TYPE_F32)
			return float_holds(o, 1'b0, a, b);
		if (etype == cpb_pkg::TYPE_F64)
			return float_holds(o, 1'b1, a, b);
		return 1'b0;
	endfunction

	// Called for every accepted element transaction.
	function void note_element(logic [63:0] a, logic [63:0] b, bit va, bit vb, bit last);
		bit hit;
		bitmap_byte_t e;
		case (mode)
			cpb_pkg::MODE_SCALAR: hit = va && holds(op, a, cmp_val);
			cpb_pkg::MODE_COLUMN: hit = va && vb && holds(op, a, b);
			cpb_pkg::MODE_RANGE: hit = va && holds(cpb_pkg::OP_GE, a, lo_val)
				&& holds(cpb_pkg::OP_LE, a, hi_val);
			default: hit = 1'b0;
		endcase
		if (hit) begin
			acc[pos] = 1'b1;
			count = count + 32'd1;
		end
		pos = pos + 3'd1;
		if (pos == 0 || last) begin
			e.bits = acc;
			e.count = count;
			e.last = last;
			pending.push_back(e);
			acc = '0;
			pos = '0;
			if (last)
				count = '0;
		end
	endfunction

	// Called for every accepted result transaction.
	function void check_byte(logic [7:0] bits, logic [31:0] cnt, logic last);
		bitmap_byte_t e;
		bytes_seen++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result byte %h count %0d last %b", $time, bits, cnt, last);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (last)
			columns_seen++;
		if (bits !== e.bits) begin
			$display("%0t: out_byte expected %h actual %h", $time, e.bits, bits);
			errors++;
		end
		if (cnt !== e.count) begin
			$display("%0t: match_count expected %0d actual %0d", $time, e.count, cnt);
			errors++;
		end
		if (last !== e.last) begin
			$display("%0t: final_byte expected %b actual %b", $time, e.last, last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 12;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;

	bitmap_scoreboard sb;
	int  cycles;
	int  rx_hold;
	bit  rx_free;
	bit  tx_burst;
	int  elements_sent;

	column_predicate_bitmap dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// All transactions are observed at the rising edge; inputs only move at the falling edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_byte(m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_element(s_axis_tdata[63:0], s_axis_tdata[127:64],
					s_axis_tuser[0], s_axis_tuser[1], s_axis_tlast);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still pending",
				cycles, sb.pending.size());
			$display("column_predicate_bitmap verification failed");
			$finish;
		end
	end

	// The result side stalls in runs of random length unless a free-flowing stretch is on.
	always @(negedge clk) begin
		if (rx_free) begin
			m_axis_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 2) != 0);
			rx_hold <= pick_gap();
		end
	end

	task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(logic [2:0] o, logic [3:0] t, logic [1:0] m,
		logic [63:0] c, logic [63:0] l, logic [63:0] h);
		write_cfg(cpb_pkg::REG_OP, {61'd0, o});
		write_cfg(cpb_pkg::REG_TYPE, {60'd0, t});
		write_cfg(cpb_pkg::REG_MODE, {62'd0, m});
		write_cfg(cpb_pkg::REG_CMP, c);
		write_cfg(cpb_pkg::REG_LOW, l);
		write_cfg(cpb_pkg::REG_HIGH, h);
	endtask

	// Presents one element transaction and returns once it is accepted.
	task automatic push_element(logic [63:0] a, logic [63:0] b, bit va, bit vb, bit last);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, a};
		s_axis_tuser <= {vb, va};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		elements_sent++;
	endtask

	// Holds off the sender until every expected byte is back and the pipeline is empty.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Operand values lean toward the configured bounds and float special values.
	function automatic logic [63:0] pick_value();
		logic [63:0] r;
		int k;
		r = {$urandom, $urandom};
		k = $urandom_range(0, 11);
		case (k)
			0: return sb.cmp_val;
			1: return sb.cmp_val + 64'd1;
			2: return sb.cmp_val - 64'd1;
			3: return sb.lo_val;
			4: return sb.hi_val;
			5: return {r[63:32], 32'h7FC0_0000 | {9'd0, r[22:0]}};
			6: return {r[63:32], r[0] ? 32'hFF80_0000 : 32'h7F80_0000};
			7: return {r[63:32], r[0], 31'd0};
			8: return r[0] ? 64'h7FF8_0000_0000_0001 : 64'hFFF0_0000_0000_0000;
			9: return {r[0], 63'd0};
			10: return r[1] ? {r[63:8], r[0], 7'd0} : {r[63:16], r[0] ? 16'h7FFF : 16'h8000};
			default: return r;
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [63:0] a, b, l, h;
		l = pick_value();
		h = pick_value();
		if ($urandom_range(0, 3) != 0 && l > h) begin
			a = l;
			l = h;
			h = a;
		end
		set_all(($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5)),
			($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9)),
			($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
			pick_value(), l, h);
		tx_burst = ($urandom_range(0, 3) == 0);
		rx_free = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++) begin
			a = pick_value();
			b = $urandom_range(0, 3) == 0 ? a : pick_value();
			if (i == n / 2 && $urandom_range(0, 2) == 0)
				drain();
			push_element(a, b, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
				(i == n - 1) ? $urandom_range(0, 3) != 0 : $urandom_range(0, 19) == 0);
		end
		drain();
	endtask

	initial begin
		sb = new();
		cycles = 0;
		elements_sent = 0;
		rx_hold = 0;
		rx_free = 1'b0;
		tx_burst = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cpb_pkg::REG_OP;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: signed 8-bit equality against zero, a short column
		// with the sign extremes, junk in the upper bits and an invalid element.
		push_element(64'h0, 64'h0, 1, 1, 0);
		push_element(64'hFFFF_FFFF_FFFF_FF00, 64'h0, 1, 1, 0);
		push_element(64'h80, 64'h0, 1, 1, 0);
		push_element(64'h7F, 64'h0, 1, 1, 0);
		push_element(64'h0, 64'h0, 0, 1, 1);
		drain();

		// Unused register index is written and must change nothing.
		write_cfg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		// Column compare across every operation on signed 64-bit extremes.
		set_all(cpb_pkg::OP_EQ, 4'd3, cpb_pkg::MODE_COLUMN, 64'h0, 64'h0, 64'h0);
		for (int o = 0; o < 8; o++) begin
			write_cfg(cpb_pkg::REG_OP, 64'(o));
			push_element(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1, 0);
			push_element(64'h5, 64'h5, 1, (o != 2), o == 7);
			drain();
		end
		// Float32 with NaN and signed zeros: not-equal is true on NaN.
		// Settings change mid-column only once the pipeline is empty.
		set_all(cpb_pkg::OP_NE, cpb_pkg::TYPE_F32, cpb_pkg::MODE_SCALAR, 64'h7FC0_0000,
			64'h0, 64'h0);
		push_element(64'h3F80_0000, 64'h0, 1, 1, 0);
		drain();
		write_cfg(cpb_pkg::REG_OP, 64'(cpb_pkg::OP_EQ));
		write_cfg(cpb_pkg::REG_CMP, 64'h0);
		push_element(64'h8000_0000, 64'h0, 1, 1, 1);
		drain();
		// Float64 range, then an empty range, undefined type and undefined mode.
		set_all(cpb_pkg::OP_EQ, cpb_pkg::TYPE_F64, cpb_pkg::MODE_RANGE, 64'h0,
			64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
		push_element(64'h0, 64'h0, 1, 1, 0);
		push_element(64'h7FF8_0000_0000_0000, 64'h0, 1, 1, 0);
		drain();
		write_cfg(cpb_pkg::REG_LOW, 64'h4000_0000_0000_0000);
		push_element(64'h3FF8_0000_0000_0000, 64'h0, 1, 1, 1);
		drain();
		set_all(cpb_pkg::OP_GE, 4'd15, cpb_pkg::MODE_SCALAR, 64'h0, 64'h0, 64'h0);
		push_element(64'h1, 64'h0, 1, 1, 0);
		drain();
		write_cfg(cpb_pkg::REG_TYPE, 64'd7);
		write_cfg(cpb_pkg::REG_MODE, 64'd3);
		push_element(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, 1, 1);
		drain();

		// Random part: about six hundred elements over many settings.
		while (elements_sent < 625)
			random_phase($urandom_range(0, 3) == 0 ? $urandom_range(40, 80) : $urandom_range(8, 30));
		rx_free = 1'b1;
		drain();

		$display("Sent %0d elements; checked %0d result bytes over %0d complete columns.",
			elements_sent, sb.bytes_seen, sb.columns_seen);
		$display("Covered all ops, all ten element types, three modes and undefined settings.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("column_predicate_bitmap verification clean");
		end else begin
			$display("%0d mismatches, %0d bytes never arrived", sb.errors, sb.pending.size());
			$display("column_predicate_bitmap verification failed");
		end
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/cpb_pkg.sv
hw/rtl/cpb_front.sv
hw/rtl/cpb_queue.sv
hw/rtl/cpb_back.sv
hw/rtl/column_predicate_bitmap.sv
dv/tb_top.sv
